### src/udp_spt_pkg.sv
// shared types and constants for the udp socket port table
// used by the table cells, the controller and the top level; no dependencies
package udp_spt_pkg;

  localparam int TableEntries = 16;
  localparam int IdxMaxW      = 8;
  localparam int CfgIdxW      = 1;
  localparam int CfgDataW     = 16;

  localparam logic [15:0] EphMinReset = 16'd49152;
  localparam logic [15:0] EphMaxReset = 16'd65535;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_BIND    = 2'd1,
    OP_DELIVER = 2'd2,
    OP_SELECT  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_SOCKET = 3'd1,
    ST_TABLE_FULL = 3'd2,
    ST_DUPLICATE  = 3'd3,
    ST_NO_MATCH   = 3'd4,
    ST_NO_PORT    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    PASS_ALLOC  = 2'd0,
    PASS_LOOKUP = 2'd1,
    PASS_BIND   = 2'd2,
    PASS_SEARCH = 2'd3
  } pass_e;

  typedef enum logic [1:0] {
    CTL_IDLE = 2'd0,
    CTL_RUN  = 2'd1,
    CTL_HOLD = 2'd2
  } ctl_state_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_EPH_MIN = 1'b0,
    CFG_EPH_MAX = 1'b1
  } cfg_idx_e;

  // token that walks the cell chain, one cell per cycle
  typedef struct packed {
    logic               valid;
    pass_e              kind;
    logic [3:0]         sock;
    logic [3:0]         ifc;
    logic [15:0]        port;
    logic [16:0]        cand;
    logic               found;
    logic               moved;
    logic [IdxMaxW-1:0] idx;
    logic               tgt_used;
    logic [3:0]         tgt_ifc;
    logic [15:0]        tgt_port;
  } tok_t;

  // entry update broadcast to all cells
  typedef struct packed {
    logic        bind_we;
    logic        port_we;
    logic [3:0]  sock;
    logic [3:0]  ifc;
    logic [15:0] port;
  } wr_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  sock;
    logic [15:0] port;
  } res_t;

endpackage

### src/udp_spt_cell.sv
// one socket entry of the port table and one stage of the token chain
// depends on udp_spt_pkg
module udp_spt_cell #(
  parameter int Idx = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  udp_spt_pkg::tok_t tok_i,
  input  udp_spt_pkg::wr_t  wr_i,
  output udp_spt_pkg::tok_t tok_o
);

  logic              used_q, used_d;
  logic [3:0]        ifc_q, ifc_d;
  logic [15:0]       port_q, port_d;
  udp_spt_pkg::tok_t tok_q, tok_d;

  logic tok_target;
  logic wr_target;
  logic compat;
  logic claim;

  assign tok_target = 32'(tok_i.sock) == 32'(Idx);
  assign wr_target  = 32'(wr_i.sock) == 32'(Idx);
  assign compat     = (ifc_q == 4'd0) || (ifc_q == tok_i.ifc);

  always_comb begin
    tok_d = tok_i;
    claim = 1'b0;
    if (tok_i.valid) begin
      if (tok_target) begin
        tok_d.tgt_used = used_q;
        tok_d.tgt_ifc  = ifc_q;
        tok_d.tgt_port = port_q;
      end
      unique case (tok_i.kind)
        udp_spt_pkg::PASS_ALLOC: begin
          if (!tok_i.found && !used_q) begin
            tok_d.found = 1'b1;
            tok_d.idx   = udp_spt_pkg::IdxMaxW'(Idx);
            claim       = 1'b1;
          end
        end
        udp_spt_pkg::PASS_LOOKUP: begin
          if (!tok_i.found && used_q && port_q == tok_i.port && compat) begin
            tok_d.found = 1'b1;
            tok_d.idx   = udp_spt_pkg::IdxMaxW'(Idx);
          end
        end
        udp_spt_pkg::PASS_BIND: begin
          if (used_q && ifc_q == tok_i.ifc && port_q == tok_i.port) begin
            tok_d.found = 1'b1;
          end
        end
        udp_spt_pkg::PASS_SEARCH: begin
          if (used_q && {1'b0, port_q} == tok_i.cand && compat) begin
            tok_d.cand  = tok_i.cand + 17'd1;
            tok_d.moved = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    used_d = used_q | claim;
    ifc_d  = ifc_q;
    port_d = port_q;
    if (wr_i.bind_we && wr_target) begin
      ifc_d  = wr_i.ifc;
      port_d = wr_i.port;
    end else if (wr_i.port_we && wr_target) begin
      port_d = wr_i.port;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      ifc_q  <= '0;
      port_q <= '0;
      tok_q  <= '0;
    end else begin
      used_q <= used_d;
      ifc_q  <= ifc_d;
      port_q <= port_d;
      tok_q  <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

### src/udp_spt_ctrl.sv
// sequencer of the port table: accepts operations, launches token passes,
// decides results, issues entry updates; holds the output register
// depends on udp_spt_pkg
module udp_spt_ctrl (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [1:0]                            operation_i,
  input  logic [3:0]                            socket_index_i,
  input  logic [3:0]                            interface_id_i,
  input  logic [15:0]                           port_i,
  input  logic                                  cfg_we_i,
  input  logic [udp_spt_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [udp_spt_pkg::CfgDataW-1:0]      cfg_data_i,
  input  udp_spt_pkg::tok_t                     tail_i,
  output udp_spt_pkg::tok_t                     launch_o,
  output udp_spt_pkg::wr_t                      wr_o,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [2:0]                            status_o,
  output logic [3:0]                            socket_out_o,
  output logic [15:0]                           port_out_o
);

  udp_spt_pkg::ctl_state_e state_q, state_d;
  udp_spt_pkg::op_e        op_q, op_d;
  logic [3:0]              sock_q, sock_d;
  logic [3:0]              ifc_q, ifc_d;
  logic [15:0]             port_q, port_d;
  logic [15:0]             eph_min_q, eph_min_d;
  logic [15:0]             eph_max_q, eph_max_d;
  udp_spt_pkg::tok_t       launch_q, launch_d;
  udp_spt_pkg::wr_t        wr_q, wr_d;
  udp_spt_pkg::res_t       res_q, res_d;
  logic                    out_valid_q, out_valid_d;
  udp_spt_pkg::res_t       out_q, out_d;

  logic              accept;
  logic              out_free;
  logic              fin;
  logic              relaunch;
  logic [16:0]       re_cand;
  logic [3:0]        re_ifc;
  logic [3:0]        use_if;
  logic [16:0]       start;
  logic [16:0]       max_ext;
  udp_spt_pkg::res_t fin_res;
  udp_spt_pkg::wr_t  fin_wr;

  assign accept   = in_valid_i && (state_q == udp_spt_pkg::CTL_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign use_if   = (tail_i.tgt_ifc != 4'd0) ? tail_i.tgt_ifc : ifc_q;
  assign start    = (eph_min_q == 16'd0) ? 17'd1 : {1'b0, eph_min_q};
  assign max_ext  = {1'b0, eph_max_q};

  // end of a pass
  always_comb begin
    fin      = 1'b0;
    relaunch = 1'b0;
    re_cand  = '0;
    re_ifc   = '0;
    fin_res  = '{status: udp_spt_pkg::ST_OK, sock: 4'd0, port: 16'd0};
    fin_wr   = '0;
    if (state_q == udp_spt_pkg::CTL_RUN && tail_i.valid) begin
      unique case (tail_i.kind)
        udp_spt_pkg::PASS_ALLOC: begin
          fin = 1'b1;
          if (tail_i.found) begin
            fin_res.sock = tail_i.idx[3:0];
          end else begin
            fin_res.status = udp_spt_pkg::ST_TABLE_FULL;
          end
        end
        udp_spt_pkg::PASS_LOOKUP: begin
          fin = 1'b1;
          if (tail_i.found) begin
            fin_res.sock = tail_i.idx[3:0];
          end else begin
            fin_res.status = udp_spt_pkg::ST_NO_MATCH;
          end
        end
        udp_spt_pkg::PASS_BIND: begin
          if (!tail_i.tgt_used) begin
            fin            = 1'b1;
            fin_res.status = udp_spt_pkg::ST_BAD_SOCKET;
          end else if (op_q == udp_spt_pkg::OP_BIND) begin
            fin = 1'b1;
            if (tail_i.found) begin
              fin_res.status = udp_spt_pkg::ST_DUPLICATE;
            end else begin
              fin_res.sock   = sock_q;
              fin_wr.bind_we = 1'b1;
              fin_wr.sock    = sock_q;
              fin_wr.ifc     = ifc_q;
              fin_wr.port    = port_q;
            end
          end else if (use_if == 4'd0) begin
            fin            = 1'b1;
            fin_res.status = udp_spt_pkg::ST_NO_PORT;
          end else if (tail_i.tgt_port != 16'd0) begin
            fin          = 1'b1;
            fin_res.sock = sock_q;
            fin_res.port = tail_i.tgt_port;
          end else if (start > max_ext) begin
            fin            = 1'b1;
            fin_res.status = udp_spt_pkg::ST_NO_PORT;
          end else begin
            relaunch = 1'b1;
            re_cand  = start;
            re_ifc   = use_if;
          end
        end
        udp_spt_pkg::PASS_SEARCH: begin
          if (tail_i.cand > max_ext) begin
            fin            = 1'b1;
            fin_res.status = udp_spt_pkg::ST_NO_PORT;
          end else if (tail_i.moved) begin
            relaunch = 1'b1;
            re_cand  = tail_i.cand;
            re_ifc   = tail_i.ifc;
          end else begin
            fin            = 1'b1;
            fin_res.sock   = sock_q;
            fin_res.port   = tail_i.cand[15:0];
            fin_wr.port_we = 1'b1;
            fin_wr.sock    = sock_q;
            fin_wr.port    = tail_i.cand[15:0];
          end
        end
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      udp_spt_pkg::CTL_IDLE: if (accept) state_d = udp_spt_pkg::CTL_RUN;
      udp_spt_pkg::CTL_RUN:  if (fin) state_d = udp_spt_pkg::CTL_HOLD;
      udp_spt_pkg::CTL_HOLD: if (out_free) state_d = udp_spt_pkg::CTL_IDLE;
      default:               state_d = udp_spt_pkg::CTL_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    op_d        = op_q;
    sock_d      = sock_q;
    ifc_d       = ifc_q;
    port_d      = port_q;
    eph_min_d   = eph_min_q;
    eph_max_d   = eph_max_q;
    launch_d    = '0;
    wr_d        = fin_wr;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    if (cfg_we_i) begin
      unique case (udp_spt_pkg::cfg_idx_e'(cfg_index_i))
        udp_spt_pkg::CFG_EPH_MIN: eph_min_d = cfg_data_i;
        udp_spt_pkg::CFG_EPH_MAX: eph_max_d = cfg_data_i;
        default: ;
      endcase
    end

    if (accept) begin
      op_d           = udp_spt_pkg::op_e'(operation_i);
      sock_d         = socket_index_i;
      ifc_d          = interface_id_i;
      port_d         = port_i;
      launch_d.valid = 1'b1;
      launch_d.sock  = socket_index_i;
      launch_d.ifc   = interface_id_i;
      launch_d.port  = port_i;
      unique case (udp_spt_pkg::op_e'(operation_i))
        udp_spt_pkg::OP_ALLOC:   launch_d.kind = udp_spt_pkg::PASS_ALLOC;
        udp_spt_pkg::OP_DELIVER: launch_d.kind = udp_spt_pkg::PASS_LOOKUP;
        udp_spt_pkg::OP_BIND:    launch_d.kind = udp_spt_pkg::PASS_BIND;
        udp_spt_pkg::OP_SELECT:  launch_d.kind = udp_spt_pkg::PASS_BIND;
        default:                 launch_d.kind = udp_spt_pkg::PASS_BIND;
      endcase
    end else if (relaunch) begin
      launch_d.valid = 1'b1;
      launch_d.kind  = udp_spt_pkg::PASS_SEARCH;
      launch_d.sock  = sock_q;
      launch_d.ifc   = re_ifc;
      launch_d.port  = port_q;
      launch_d.cand  = re_cand;
    end

    if (fin) begin
      res_d = fin_res;
    end

    if (state_q == udp_spt_pkg::CTL_HOLD && out_free) begin
      out_valid_d = 1'b1;
      out_d       = res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= udp_spt_pkg::CTL_IDLE;
      eph_min_q   <= udp_spt_pkg::EphMinReset;
      eph_max_q   <= udp_spt_pkg::EphMaxReset;
      launch_q    <= '0;
      wr_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      eph_min_q   <= eph_min_d;
      eph_max_q   <= eph_max_d;
      launch_q    <= launch_d;
      wr_q        <= wr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    sock_q <= sock_d;
    ifc_q  <= ifc_d;
    port_q <= port_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign in_stall_o   = state_q != udp_spt_pkg::CTL_IDLE;
  assign launch_o     = launch_q;
  assign wr_o         = wr_q;
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_q.status;
  assign socket_out_o = out_q.sock;
  assign port_out_o   = out_q.port;

endmodule

### src/udp_socket_port_table.sv
// udp socket port table: one operation at a time (allocate, bind, deliver lookup,
// source port select) over a chain of TableEntries entry cells. Every operation
// sends a token down the chain one cell per cycle; allocate, bind and deliver
// take one pass. Source select takes one pass to read the socket and, for an
// unbound socket, one more pass per port collision run, at most TableEntries + 1
// search passes. The table is cleared at reset and needs no clearing time; the
// next operation is taken while a result still waits in the output register.
// Configuration must be written only while idle; the block itself does not
// enforce this.
module udp_socket_port_table #(
  parameter int TableEntries = udp_spt_pkg::TableEntries
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       operation_i,
  input  logic [3:0]                       socket_index_i,
  input  logic [3:0]                       interface_id_i,
  input  logic [15:0]                      port_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [2:0]                       status_o,
  output logic [3:0]                       socket_out_o,
  output logic [15:0]                      port_out_o,
  input  logic                             cfg_we_i,
  input  logic [udp_spt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [udp_spt_pkg::CfgDataW-1:0] cfg_data_i
);

  udp_spt_pkg::tok_t       chain [TableEntries+1];
  udp_spt_pkg::wr_t        wr;
  logic [TableEntries:0]   tok_valid;

  udp_spt_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .socket_index_i (socket_index_i),
    .interface_id_i (interface_id_i),
    .port_i         (port_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .tail_i         (chain[TableEntries]),
    .launch_o       (chain[0]),
    .wr_o           (wr),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .socket_out_o   (socket_out_o),
    .port_out_o     (port_out_o)
  );

  for (genvar i = 0; i < TableEntries; i++) begin : g_cell
    udp_spt_cell #(
      .Idx (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (chain[i]),
      .wr_i   (wr),
      .tok_o  (chain[i+1])
    );
  end

  for (genvar i = 0; i <= TableEntries; i++) begin : g_valid
    assign tok_valid[i] = chain[i].valid;
  end

`ifndef ASSERT_OFF
  a_single_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_valid))
    else $error("more than one token in the chain");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again while an operation is running");

  a_clean_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != udp_spt_pkg::ST_OK |-> socket_out_o == 4'd0 &&
      port_out_o == 16'd0)
    else $error("error result carries socket or port");

  a_no_token_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> tok_valid == '0)
    else $error("token in flight while idle");
`endif

endmodule
